// ===== hdl/itp_pkg.sv =====
// shared types, codes and character tables for the infix to postfix converter
`timescale 1ns / 1ps

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CODE_W      = 3;
    localparam int CHAR_W      = 8;
    localparam int PREC_W      = 2;
    localparam int ERR_W       = 2;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [PREC_W-1:0] prec_t;
    typedef logic [ERR_W-1:0]  err_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // stack entry codes
    localparam code_t CODE_OPEN = 3'd0;
    localparam code_t CODE_ADD  = 3'd1;
    localparam code_t CODE_SUB  = 3'd2;
    localparam code_t CODE_MUL  = 3'd3;
    localparam code_t CODE_DIV  = 3'd4;

    localparam char_t CHAR_OPEN  = 8'h28;
    localparam char_t CHAR_CLOSE = 8'h29;
    localparam char_t CHAR_PLUS  = 8'h2b;
    localparam char_t CHAR_MINUS = 8'h2d;
    localparam char_t CHAR_STAR  = 8'h2a;
    localparam char_t CHAR_SLASH = 8'h2f;
    localparam char_t CHAR_NUL   = 8'h00;

    localparam prec_t PREC_OPEN = 2'd0;
    localparam prec_t PREC_ADD  = 2'd1;
    localparam prec_t PREC_MUL  = 2'd2;

    localparam err_t ERR_NONE      = 2'd0;
    localparam err_t ERR_FULL      = 2'd1;
    localparam err_t ERR_UNMATCHED = 2'd2;

    // request kinds
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_END   = 3'd0;
    localparam kind_t KIND_OP    = 3'd1;
    localparam kind_t KIND_OPEN  = 3'd2;
    localparam kind_t KIND_CLOSE = 3'd3;
    localparam kind_t KIND_OTHER = 3'd4;

    // stack operations
    typedef logic [1:0] stk_op_t;
    localparam stk_op_t STK_NONE    = 2'd0;
    localparam stk_op_t STK_PUSH    = 2'd1;
    localparam stk_op_t STK_POP     = 2'd2;
    localparam stk_op_t STK_REPLACE = 2'd3;

    // result sources
    typedef logic [2:0] emit_sel_t;
    localparam emit_sel_t EMIT_TOP       = 3'd0;
    localparam emit_sel_t EMIT_CHAR      = 3'd1;
    localparam emit_sel_t EMIT_TERM      = 3'd2;
    localparam emit_sel_t EMIT_FULL      = 3'd3;
    localparam emit_sel_t EMIT_UNMATCHED = 3'd4;

    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  full;
        logic  pop_cond;
        logic  more_pop;
        logic  top_open;
        logic  second_open;
        logic  out_free;
    } status_t;

    typedef struct packed {
        logic      load;
        stk_op_t   stk_op;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } cmd_t;

    function automatic char_t code_char(input code_t code);
        char_t ch;
        case (code)
            CODE_ADD: ch = CHAR_PLUS;
            CODE_SUB: ch = CHAR_MINUS;
            CODE_MUL: ch = CHAR_STAR;
            CODE_DIV: ch = CHAR_SLASH;
            default:  ch = CHAR_OPEN;
        endcase
        return ch;
    endfunction

    function automatic prec_t code_prec(input code_t code);
        prec_t p;
        case (code)
            CODE_ADD, CODE_SUB: p = PREC_ADD;
            CODE_MUL, CODE_DIV: p = PREC_MUL;
            default:            p = PREC_OPEN;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/itp_dp.sv =====
// datapath: request register, operator stack, output register
`timescale 1ns / 1ps

module itp_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  itp_pkg::cmd_t        cmd,
    input  logic                 s_mode,
    input  itp_pkg::char_t       s_in_char,
    input  logic                 m_ready,
    output itp_pkg::status_t     status,
    output logic                 m_valid,
    output itp_pkg::char_t       m_out_char,
    output logic                 m_last,
    output logic                 m_end_of_expr,
    output itp_pkg::err_t        m_error
);

    itp_pkg::kind_t  kind_reg;
    itp_pkg::code_t  code_reg;
    itp_pkg::char_t  char_reg;
    itp_pkg::kind_t  in_kind;
    itp_pkg::code_t  in_code;

    itp_pkg::code_t  stk_reg  [itp_pkg::STACK_DEPTH];
    itp_pkg::code_t  stk_next [itp_pkg::STACK_DEPTH];
    itp_pkg::cnt_t   count_reg;
    itp_pkg::cnt_t   count_next;

    logic            m_valid_reg;
    logic            m_valid_next;
    itp_pkg::char_t  m_out_char_reg;
    logic            m_last_reg;
    logic            m_end_of_expr_reg;
    itp_pkg::err_t   m_error_reg;
    itp_pkg::char_t  emit_char;
    logic            emit_eoe;
    itp_pkg::err_t   emit_err;

    // classify the incoming request
    always_comb begin
        in_kind = itp_pkg::KIND_OTHER;
        in_code = itp_pkg::CODE_OPEN;
        if (s_mode) begin
            in_kind = itp_pkg::KIND_END;
        end else begin
            case (s_in_char)
                itp_pkg::CHAR_OPEN: begin
                    in_kind = itp_pkg::KIND_OPEN;
                end
                itp_pkg::CHAR_CLOSE: begin
                    in_kind = itp_pkg::KIND_CLOSE;
                end
                itp_pkg::CHAR_PLUS: begin
                    in_kind = itp_pkg::KIND_OP;
                    in_code = itp_pkg::CODE_ADD;
                end
                itp_pkg::CHAR_MINUS: begin
                    in_kind = itp_pkg::KIND_OP;
                    in_code = itp_pkg::CODE_SUB;
                end
                itp_pkg::CHAR_STAR: begin
                    in_kind = itp_pkg::KIND_OP;
                    in_code = itp_pkg::CODE_MUL;
                end
                itp_pkg::CHAR_SLASH: begin
                    in_kind = itp_pkg::KIND_OP;
                    in_code = itp_pkg::CODE_DIV;
                end
                default: begin
                    in_kind = itp_pkg::KIND_OTHER;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            code_reg <= in_code;
            char_reg <= s_in_char;
        end
    end

    // stack as a shift line, entry 0 is the top
    always_comb begin
        for (int i = 0; i < itp_pkg::STACK_DEPTH; i++) begin
            stk_next[i] = stk_reg[i];
        end
        count_next = count_reg;
        case (cmd.stk_op)
            itp_pkg::STK_PUSH: begin
                stk_next[0] = code_reg;
                for (int i = 1; i < itp_pkg::STACK_DEPTH; i++) begin
                    stk_next[i] = stk_reg[i-1];
                end
                count_next = count_reg + itp_pkg::cnt_t'(1);
            end
            itp_pkg::STK_POP: begin
                for (int i = 0; i < itp_pkg::STACK_DEPTH - 1; i++) begin
                    stk_next[i] = stk_reg[i+1];
                end
                count_next = count_reg - itp_pkg::cnt_t'(1);
            end
            itp_pkg::STK_REPLACE: begin
                stk_next[0] = code_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < itp_pkg::STACK_DEPTH; i++) begin
            stk_reg[i] <= stk_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        status.kind        = kind_reg;
        status.count_zero  = (count_reg == '0);
        status.full        = (count_reg == itp_pkg::cnt_t'(itp_pkg::STACK_DEPTH));
        status.pop_cond    = itp_pkg::code_prec(code_reg) <= itp_pkg::code_prec(stk_reg[0]);
        status.more_pop    = (count_reg > itp_pkg::cnt_t'(1))
                           && (itp_pkg::code_prec(code_reg) <= itp_pkg::code_prec(stk_reg[1]));
        status.top_open    = (stk_reg[0] == itp_pkg::CODE_OPEN);
        status.second_open = (count_reg > itp_pkg::cnt_t'(1))
                           && (stk_reg[1] == itp_pkg::CODE_OPEN);
        status.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        emit_char = itp_pkg::CHAR_NUL;
        emit_eoe  = 1'b0;
        emit_err  = itp_pkg::ERR_NONE;
        case (cmd.emit_sel)
            itp_pkg::EMIT_TOP:       emit_char = itp_pkg::code_char(stk_reg[0]);
            itp_pkg::EMIT_CHAR:      emit_char = char_reg;
            itp_pkg::EMIT_TERM:      emit_eoe  = 1'b1;
            itp_pkg::EMIT_FULL:      emit_err  = itp_pkg::ERR_FULL;
            itp_pkg::EMIT_UNMATCHED: emit_err  = itp_pkg::ERR_UNMATCHED;
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_out_char_reg    <= emit_char;
            m_last_reg        <= cmd.emit_last;
            m_end_of_expr_reg <= emit_eoe;
            m_error_reg       <= emit_err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_out_char_reg;
    assign m_last        = m_last_reg;
    assign m_end_of_expr = m_end_of_expr_reg;
    assign m_error       = m_error_reg;

endmodule

// ===== hdl/itp_ctrl.sv =====
// controller: sequences stack pops, pushes and results for one request
`timescale 1ns / 1ps

module itp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  itp_pkg::status_t   status,
    output logic               s_ready,
    output itp_pkg::cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic state_reg;
    logic state_next;
    logic done;

    always_comb begin
        cmd            = '0;
        cmd.stk_op     = itp_pkg::STK_NONE;
        cmd.emit_sel   = itp_pkg::EMIT_TOP;
        done           = 1'b0;
        s_ready        = (state_reg == ST_IDLE);
        state_next     = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                case (status.kind)
                    itp_pkg::KIND_END: begin
                        cmd.emit = 1'b1;
                        if (!status.count_zero) begin
                            cmd.stk_op = itp_pkg::STK_POP;
                        end else begin
                            cmd.emit_sel  = itp_pkg::EMIT_TERM;
                            cmd.emit_last = 1'b1;
                            done          = 1'b1;
                        end
                    end
                    itp_pkg::KIND_OP: begin
                        if (!status.count_zero && status.pop_cond) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = !status.more_pop;
                            if (status.more_pop) begin
                                cmd.stk_op = itp_pkg::STK_POP;
                            end else begin
                                // last pop and the push fold into one overwrite
                                cmd.stk_op = itp_pkg::STK_REPLACE;
                                done       = 1'b1;
                            end
                        end else if (status.full) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = itp_pkg::EMIT_FULL;
                            cmd.emit_last = 1'b1;
                            done          = 1'b1;
                        end else begin
                            cmd.stk_op = itp_pkg::STK_PUSH;
                            done       = 1'b1;
                        end
                    end
                    itp_pkg::KIND_OPEN: begin
                        if (status.full) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = itp_pkg::EMIT_FULL;
                            cmd.emit_last = 1'b1;
                        end else begin
                            cmd.stk_op = itp_pkg::STK_PUSH;
                        end
                        done = 1'b1;
                    end
                    itp_pkg::KIND_CLOSE: begin
                        if (status.count_zero) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = itp_pkg::EMIT_UNMATCHED;
                            cmd.emit_last = 1'b1;
                            done          = 1'b1;
                        end else if (status.top_open) begin
                            cmd.stk_op = itp_pkg::STK_POP;
                            done       = 1'b1;
                        end else begin
                            // last when the matching open sits right below
                            cmd.emit      = 1'b1;
                            cmd.emit_last = status.second_open;
                            cmd.stk_op    = itp_pkg::STK_POP;
                        end
                    end
                    default: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = itp_pkg::EMIT_CHAR;
                        cmd.emit_last = 1'b1;
                        done          = 1'b1;
                    end
                endcase
                // hold everything while the output register is occupied
                if (cmd.emit && !status.out_free) begin
                    cmd.emit   = 1'b0;
                    cmd.stk_op = itp_pkg::STK_NONE;
                    done       = 1'b0;
                end
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/infix_to_postfix_converter_unit.sv =====
// top level of the infix to postfix converter
`timescale 1ns / 1ps

// Converts an infix expression, one character per request, to postfix.
// Input channel s_*: s_mode 0 carries a character in s_in_char, s_mode 1
// ends the expression and flushes the operator stack.
// Output channel m_*: one character per result on m_out_char; m_last marks
// the final result of a request, m_end_of_expr the terminator after a flush,
// m_error 1 for a dropped push on a full stack, 2 for an unmatched ')'.
// A request is taken in the idle state into the request register; the work
// state then pops one stack entry per cycle while the output register can
// take its results. A ')' that ends on its '(' after popping, an unmatched
// ')' after its pops and an end flush, which adds the terminator, take a
// further step after their pops. A request that gives no result (pushed '('
// or operator, ')' that meets its '(' at once) still passes through the work
// state. The first result of a request passes through the request register
// and then the output register.
// Results pass through an output register; while m_ready is low and that
// register is full, a step that gives a result holds and s_ready stays low.
// Reset empties the stack and the output register; the block is ready once
// reset is released.
module infix_to_postfix_converter_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  itp_pkg::char_t       s_in_char,
    output logic                 m_valid,
    input  logic                 m_ready,
    output itp_pkg::char_t       m_out_char,
    output logic                 m_last,
    output logic                 m_end_of_expr,
    output itp_pkg::err_t        m_error
);

    itp_pkg::status_t status;
    itp_pkg::cmd_t    cmd;

    itp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    itp_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_mode        (s_mode),
        .s_in_char     (s_in_char),
        .m_ready       (m_ready),
        .status        (status),
        .m_valid       (m_valid),
        .m_out_char    (m_out_char),
        .m_last        (m_last),
        .m_end_of_expr (m_end_of_expr),
        .m_error       (m_error)
    );

    // the terminator is always the final, clean result of its request
    a_term_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_expr |-> m_last && (m_out_char == itp_pkg::CHAR_NUL)
            && (m_error == itp_pkg::ERR_NONE))
        else $error("terminator result malformed");

    // error results carry no character and close their request
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error != itp_pkg::ERR_NONE) |-> m_last
            && (m_out_char == itp_pkg::CHAR_NUL) && !m_end_of_expr)
        else $error("error result malformed");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_error == itp_pkg::ERR_NONE) || (m_error == itp_pkg::ERR_FULL)
            || (m_error == itp_pkg::ERR_UNMATCHED))
        else $error("undefined error code");

    // one request at a time: the cycle after a request is taken, the input is closed
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken during work");

endmodule

// ===== tb/tb_infix_to_postfix_converter_unit.sv =====
// self-checking testbench for the infix to postfix converter unit
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_unit;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASE_ITEMS  = 125;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned MAX_PRINTED  = 25;

    typedef struct packed {
        itp_pkg::char_t ch;
        logic           last;
        logic           eoe;
        itp_pkg::err_t  err;
    } postfix_res_t;

    typedef struct packed {
        logic           mode;
        itp_pkg::char_t ch;
    } request_t;

    typedef struct packed {
        logic           mode;
        itp_pkg::char_t ch;
        logic           typed;
        itp_pkg::char_t want_ch;
        logic           want_eoe;
        itp_pkg::err_t  want_err;
    } dir_row_t;

    logic           aclk;
    logic           aresetn       = 1'b0;
    logic           s_valid       = 1'b0;
    logic           s_ready;
    logic           s_mode        = 1'b0;
    itp_pkg::char_t s_in_char     = itp_pkg::CHAR_NUL;
    logic           m_valid;
    logic           m_ready       = 1'b0;
    itp_pkg::char_t m_out_char;
    logic           m_last;
    logic           m_end_of_expr;
    itp_pkg::err_t  m_error;

    // shadow operator stack
    itp_pkg::code_t shadow_stack [itp_pkg::STACK_DEPTH];
    int unsigned    shadow_depth = 0;

    postfix_res_t step_out [$];
    postfix_res_t pending_postfix [$];
    request_t     burst [$];
    dir_row_t     dir_rows [25];

    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    bit          long_hold_go    = 1'b0;
    bit          long_hold_taken = 1'b0;
    int unsigned hold_left       = 0;

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned requests_sent = 0;
    int unsigned most_per_req  = 0;
    int unsigned full_drops    = 0;
    int unsigned unmatched     = 0;
    int unsigned terminators   = 0;

    infix_to_postfix_converter_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_in_char     (s_in_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last),
        .m_end_of_expr (m_end_of_expr),
        .m_error       (m_error)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_postfix.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic itp_pkg::char_t op_char(input itp_pkg::code_t code);
        itp_pkg::char_t ch;
        if (code == itp_pkg::CODE_ADD)      ch = "+";
        else if (code == itp_pkg::CODE_SUB) ch = "-";
        else if (code == itp_pkg::CODE_MUL) ch = "*";
        else if (code == itp_pkg::CODE_DIV) ch = "/";
        else                                ch = "(";
        return ch;
    endfunction

    function automatic int unsigned op_rank(input itp_pkg::code_t code);
        int unsigned rank;
        if (code == itp_pkg::CODE_OPEN) rank = 0;
        else if (code == itp_pkg::CODE_MUL || code == itp_pkg::CODE_DIV) rank = 2;
        else rank = 1;
        return rank;
    endfunction

    function automatic void emit_postfix(input itp_pkg::char_t ch, input logic eoe,
                                         input itp_pkg::err_t err);
        postfix_res_t r;
        r.ch   = ch;
        r.last = 1'b0;
        r.eoe  = eoe;
        r.err  = err;
        step_out.push_back(r);
    endfunction

    function automatic void push_shadow(input itp_pkg::code_t code);
        if (shadow_depth >= itp_pkg::STACK_DEPTH) begin
            emit_postfix(itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_FULL);
        end else begin
            shadow_stack[shadow_depth] = code;
            shadow_depth++;
        end
    endfunction

    // shunting-yard step for one request, results land in step_out
    function automatic void shunt(input logic mode, input itp_pkg::char_t ch);
        itp_pkg::code_t code;
        int unsigned    rank;
        bit             found;
        postfix_res_t   tail;
        step_out.delete();
        if (mode) begin
            while (shadow_depth > 0) begin
                emit_postfix(op_char(shadow_stack[shadow_depth - 1]), 1'b0,
                             itp_pkg::ERR_NONE);
                shadow_depth--;
            end
            emit_postfix(itp_pkg::CHAR_NUL, 1'b1, itp_pkg::ERR_NONE);
        end else if (ch == itp_pkg::CHAR_PLUS || ch == itp_pkg::CHAR_MINUS
                     || ch == itp_pkg::CHAR_STAR || ch == itp_pkg::CHAR_SLASH) begin
            if (ch == itp_pkg::CHAR_PLUS)       code = itp_pkg::CODE_ADD;
            else if (ch == itp_pkg::CHAR_MINUS) code = itp_pkg::CODE_SUB;
            else if (ch == itp_pkg::CHAR_STAR)  code = itp_pkg::CODE_MUL;
            else                                code = itp_pkg::CODE_DIV;
            rank = op_rank(code);
            while (shadow_depth > 0 && rank <= op_rank(shadow_stack[shadow_depth - 1])) begin
                emit_postfix(op_char(shadow_stack[shadow_depth - 1]), 1'b0,
                             itp_pkg::ERR_NONE);
                shadow_depth--;
            end
            push_shadow(code);
        end else if (ch == itp_pkg::CHAR_OPEN) begin
            push_shadow(itp_pkg::CODE_OPEN);
        end else if (ch == itp_pkg::CHAR_CLOSE) begin
            found = 1'b0;
            while (shadow_depth > 0 && !found) begin
                code = shadow_stack[shadow_depth - 1];
                shadow_depth--;
                if (code == itp_pkg::CODE_OPEN) found = 1'b1;
                else emit_postfix(op_char(code), 1'b0, itp_pkg::ERR_NONE);
            end
            if (!found) emit_postfix(itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_UNMATCHED);
        end else begin
            emit_postfix(ch, 1'b0, itp_pkg::ERR_NONE);
        end
        if (step_out.size() > 0) begin
            tail = step_out[step_out.size() - 1];
            tail.last = 1'b1;
            step_out[step_out.size() - 1] = tail;
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch on result %0d at cycle %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, cycle_count, what, got, want);
    endtask

    task automatic check_postfix();
        postfix_res_t want;
        results_seen++;
        if (pending_postfix.size() == 0) begin
            report_mismatch("unexpected result, out_char", 32'(m_out_char), 0);
        end else begin
            want = pending_postfix.pop_front();
            if (m_out_char !== want.ch)
                report_mismatch("out_char", 32'(m_out_char), 32'(want.ch));
            if (m_last !== want.last)
                report_mismatch("last", 32'(m_last), 32'(want.last));
            if (m_end_of_expr !== want.eoe)
                report_mismatch("end_of_expr", 32'(m_end_of_expr), 32'(want.eoe));
            if (m_error !== want.err)
                report_mismatch("error", 32'(m_error), 32'(want.err));
            if (want.err == itp_pkg::ERR_FULL)      full_drops++;
            if (want.err == itp_pkg::ERR_UNMATCHED) unmatched++;
            if (want.eoe)                           terminators++;
        end
    endtask

    // result side: check, then pick m_ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_postfix();
        if (long_hold_go && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic mode, input itp_pkg::char_t ch,
                                input bit use_typed, input postfix_res_t typed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_in_char <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shunt(mode, ch);
        if (step_out.size() > most_per_req) most_per_req = step_out.size();
        if (use_typed) pending_postfix.push_back(typed_res);
        else foreach (step_out[i]) pending_postfix.push_back(step_out[i]);
        requests_sent++;
    endtask

    function automatic itp_pkg::char_t rand_operator();
        itp_pkg::char_t ch;
        case ($urandom_range(3))
            0:       ch = itp_pkg::CHAR_PLUS;
            1:       ch = itp_pkg::CHAR_MINUS;
            2:       ch = itp_pkg::CHAR_STAR;
            default: ch = itp_pkg::CHAR_SLASH;
        endcase
        return ch;
    endfunction

    function automatic itp_pkg::char_t rand_operand();
        itp_pkg::char_t ch;
        int unsigned    pick;
        pick = $urandom_range(9);
        if (pick < 6) begin
            ch = itp_pkg::char_t'("a" + $urandom_range(25));
        end else if (pick < 9) begin
            ch = itp_pkg::char_t'("0" + $urandom_range(9));
        end else begin
            do ch = itp_pkg::char_t'($urandom_range(255));
            while (ch == itp_pkg::CHAR_OPEN || ch == itp_pkg::CHAR_CLOSE
                   || ch == itp_pkg::CHAR_PLUS || ch == itp_pkg::CHAR_MINUS
                   || ch == itp_pkg::CHAR_STAR || ch == itp_pkg::CHAR_SLASH);
        end
        return ch;
    endfunction

    function automatic void add_req(input logic mode, input itp_pkg::char_t ch);
        request_t r;
        r.mode = mode;
        r.ch   = ch;
        burst.push_back(r);
    endfunction

    // expression with random nesting; sloppy adds stray ')' and missing ends
    function automatic void gen_expression(input bit sloppy);
        int unsigned terms;
        int unsigned depth;
        terms = $urandom_range(1, 8);
        depth = 0;
        for (int unsigned t = 0; t < terms; t++) begin
            while ($urandom_range(3) == 0 && depth < 8) begin
                add_req(1'b0, itp_pkg::CHAR_OPEN);
                depth++;
            end
            add_req(1'b0, rand_operand());
            while (depth > 0 && $urandom_range(2) == 0) begin
                add_req(1'b0, itp_pkg::CHAR_CLOSE);
                depth--;
            end
            if (sloppy && $urandom_range(4) == 0) add_req(1'b0, itp_pkg::CHAR_CLOSE);
            if (t != terms - 1) add_req(1'b0, rand_operator());
            if (sloppy && $urandom_range(5) == 0) add_req(1'b0, rand_operator());
        end
        // now and then leave a '(' open for the flush
        while (depth > 0 && $urandom_range(7) != 0) begin
            add_req(1'b0, itp_pkg::CHAR_CLOSE);
            depth--;
        end
        if (!sloppy || $urandom_range(2) != 0)
            add_req(1'b1, itp_pkg::char_t'($urandom_range(255)));
    endfunction

    // deep nesting, runs the stack into full and the flush to its longest
    function automatic void gen_deep();
        int unsigned levels;
        levels = $urandom_range(16, 36);
        repeat (levels) begin
            add_req(1'b0, itp_pkg::CHAR_OPEN);
            if ($urandom_range(1)) add_req(1'b0, rand_operand());
            if ($urandom_range(1)) add_req(1'b0, rand_operator());
        end
        repeat ($urandom_range(0, 3)) add_req(1'b0, itp_pkg::CHAR_CLOSE);
        add_req(1'b1, itp_pkg::CHAR_NUL);
    endfunction

    function automatic void gen_noise();
        itp_pkg::char_t ch;
        repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(1)) begin
                case ($urandom_range(2))
                    0:       ch = itp_pkg::CHAR_OPEN;
                    1:       ch = itp_pkg::CHAR_CLOSE;
                    default: ch = rand_operator();
                endcase
            end else begin
                ch = itp_pkg::char_t'($urandom_range(255));
            end
            add_req($urandom_range(9) == 0, ch);
        end
    endfunction

    initial begin
        postfix_res_t typed_res;
        int unsigned  pick;
        int unsigned  phase_goal;

        dir_rows = '{
            '{1'b1, itp_pkg::CHAR_OPEN,  1'b1, itp_pkg::CHAR_NUL, 1'b1, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_NUL,   1'b1, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, 8'hff,               1'b1, 8'hff,             1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_CLOSE, 1'b1, itp_pkg::CHAR_NUL, 1'b0,
              itp_pkg::ERR_UNMATCHED},
            '{1'b0, itp_pkg::CHAR_OPEN,  1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, "a",                 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_PLUS,  1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, "b",                 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_CLOSE, 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_STAR,  1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, "c",                 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_MINUS, 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, "d",                 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_SLASH, 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, "e",                 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b1, itp_pkg::CHAR_NUL,   1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_OPEN,  1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_CLOSE, 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_MINUS, 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_OPEN,  1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b1, 8'hff,               1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_PLUS,  1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, "y",                 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b0, itp_pkg::CHAR_CLOSE, 1'b0, itp_pkg::CHAR_NUL, 1'b0, itp_pkg::ERR_NONE},
            '{1'b1, itp_pkg::CHAR_NUL,   1'b1, itp_pkg::CHAR_NUL, 1'b1, itp_pkg::ERR_NONE}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; typed ones give a single result
        foreach (dir_rows[i]) begin
            typed_res.ch   = dir_rows[i].want_ch;
            typed_res.last = 1'b1;
            typed_res.eoe  = dir_rows[i].want_eoe;
            typed_res.err  = dir_rows[i].want_err;
            send_request(dir_rows[i].mode, dir_rows[i].ch, dir_rows[i].typed, typed_res);
        end

        // random phases: no idling, sender idle, receiver stall, both
        for (int unsigned phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            // output held off while requests keep coming, fills the block
            if (phase == 0) long_hold_go = 1'b1;
            phase_goal = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_goal) begin
                burst.delete();
                pick = $urandom_range(99);
                if (pick < 60)      gen_expression(1'b0);
                else if (pick < 70) gen_deep();
                else if (pick < 85) gen_expression(1'b1);
                else                gen_noise();
                foreach (burst[i]) send_request(burst[i].mode, burst[i].ch, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_postfix.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d directed) and %0d results, up to %0d per request",
                 requests_sent, $size(dir_rows), results_seen, most_per_req);
        $display("stack-full drops %0d, unmatched closes %0d, terminators %0d, mismatches %0d",
                 full_drops, unmatched, terminators, mismatches);
        if (mismatches == 0 && pending_postfix.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
